FILE: hw/rtl/rclc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclc_pkg
// Shared constants, codes and controller/datapath interface types for the
// relay channel lock controller.
// ----------------------------------------------------------------------------
package rclc_pkg;

    localparam int MAX_MODULES = 8;
    localparam int MOD_W       = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
    localparam int N_W         = $clog2(MAX_MODULES + 1);

    localparam int OP_W       = 3;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_OPEN    = 3'd0;
    localparam logic [OP_W-1:0] OP_CLOSE   = 3'd1;
    localparam logic [OP_W-1:0] OP_LOCK    = 3'd2;
    localparam logic [OP_W-1:0] OP_UNLOCK  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd5;
    localparam logic [OP_W-1:0] OP_ALL_OFF = 3'd6;
    localparam logic [OP_W-1:0] OP_NONE    = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERTED       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_TICKS  = 2'd3;

    localparam logic [CH_W-1:0] CH_INVALID = 8'hFF;
    localparam logic [15:0]     REFRESH_RESET = 16'd60000;

    // controller -> datapath
    typedef struct packed {
        logic             capture;
        logic             exec_cmd;
        logic             exec_tick;
        logic             exec_all_off;
        logic             load_byte;
        logic [MOD_W-1:0] emit_idx;
    } rclc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            tick_emit;
        logic [N_W-1:0]  used_n;
    } rclc_status_t;

    // module flags repeat every 8 modules
    function automatic logic flag_of(input logic [7:0] mask, input logic [4:0] m);
        return mask[m[2:0]];
    endfunction

endpackage

FILE: hw/rtl/rclc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclc_ctrl
// Sequencer: takes one command and executes it; for a rewrite or all-off it
// then walks the module bytes out through the output register, last module first.
// ----------------------------------------------------------------------------
module rclc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  rclc_pkg::rclc_status_t st,
    output rclc_pkg::rclc_cmd_t    cmd
);
    import rclc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [MOD_W-1:0] emit_reg, emit_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             used_zero;
    logic [MOD_W-1:0] last_idx;

    assign out_free  = !out_valid_reg || !out_stall;
    assign used_zero = (st.used_n == '0);
    assign last_idx  = MOD_W'(st.used_n - N_W'(1));
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        emit_next        = emit_reg;
        cmd              = '0;
        cmd.emit_idx     = emit_reg;
        cmd.capture      = (state_reg == S_IDLE) && in_valid;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (st.op == OP_TICK)
                begin
                    cmd.exec_tick = 1'b1;
                    emit_next     = last_idx;
                    state_next    = (st.tick_emit && !used_zero) ? S_EMIT : S_IDLE;
                end
                else if (st.op == OP_ALL_OFF)
                begin
                    cmd.exec_all_off = 1'b1;
                    emit_next        = last_idx;
                    state_next       = used_zero ? S_IDLE : S_EMIT;
                end
                else if (st.op == OP_NONE)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    if (out_free)
                    begin
                        cmd.exec_cmd = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_byte = 1'b1;
                    if (emit_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_next = emit_reg - MOD_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.exec_cmd || cmd.load_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/rclc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclc_datapath
// Configuration registers, per-module on/lock/saved bytes, tick counter and
// the output payload register.
// ----------------------------------------------------------------------------
module rclc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rclc_pkg::OP_W-1:0]     op,
    input  logic [rclc_pkg::CH_W-1:0]     channel,
    input  logic                          lock_level,
    input  logic                          cfg_we,
    input  logic [rclc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rclc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  rclc_pkg::rclc_cmd_t           cmd,
    output rclc_pkg::rclc_status_t        st,
    output logic                          kind,
    output logic                          accepted,
    output logic                          channel_on,
    output logic [7:0]                    shift_byte,
    output logic                          latch_now
);
    import rclc_pkg::*;

    // configuration
    logic [3:0]  module_count_reg;
    logic [7:0]  active_low_reg;
    logic [7:0]  inverted_reg;
    logic [15:0] refresh_reg;

    // channel state, kept at physical bit positions
    logic [7:0] on_reg    [MAX_MODULES];
    logic [7:0] lock_reg  [MAX_MODULES];
    logic [7:0] saved_reg [MAX_MODULES];
    logic [7:0] on_next   [MAX_MODULES];
    logic [7:0] lock_next [MAX_MODULES];
    logic [7:0] saved_next[MAX_MODULES];
    logic       pending_reg, pending_next;
    logic [15:0] ticks_reg, ticks_next;

    // captured command
    logic [OP_W-1:0] op_reg;
    logic [CH_W-1:0] ch_reg;
    logic            level_reg;

    // output payload
    logic       kind_reg, accepted_reg, chon_reg, latch_reg;
    logic [7:0] byte_reg;
    logic       kind_next, accepted_next, chon_next, latch_next;
    logic [7:0] byte_next;

    logic [N_W-1:0]   used_n;
    logic [CH_W-1:0]  c_m1;
    logic [4:0]       mod5;
    logic             hit;
    logic [MOD_W-1:0] cm;
    logic [2:0]       bit_pos;
    logic [7:0]       mask;
    logic [7:0]       on_sel, lock_sel, saved_sel;
    logic             locked;
    logic [15:0]      ticks_inc;
    logic             tick_pend;
    logic [7:0]       raw_byte;

    assign used_n = N_W'((int'(module_count_reg) > MAX_MODULES) ? MAX_MODULES
                                                                : int'(module_count_reg));

    assign c_m1    = ch_reg - CH_W'(1);
    assign mod5    = c_m1[7:3];
    assign hit     = (ch_reg != '0) && (ch_reg != CH_INVALID) && (int'(mod5) < int'(used_n));
    assign cm      = hit ? MOD_W'(mod5) : '0;
    assign bit_pos = flag_of(inverted_reg, mod5) ? (3'd7 - c_m1[2:0]) : c_m1[2:0];
    assign mask    = 8'd1 << bit_pos;

    assign on_sel    = on_reg[cm];
    assign lock_sel  = lock_reg[cm];
    assign saved_sel = saved_reg[cm];
    assign locked    = (lock_sel & mask) != '0;

    assign ticks_inc = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
    assign tick_pend = pending_reg || (ticks_inc >= refresh_reg);

    assign raw_byte = flag_of(active_low_reg, 5'(cmd.emit_idx)) ? ~on_reg[cmd.emit_idx]
                                                                : on_reg[cmd.emit_idx];

    assign st.op        = op_reg;
    assign st.tick_emit = tick_pend;
    assign st.used_n    = used_n;

    always_comb
    begin
        for (int i = 0; i < MAX_MODULES; i++)
        begin
            on_next[i]    = on_reg[i];
            lock_next[i]  = lock_reg[i];
            saved_next[i] = saved_reg[i];
        end
        pending_next  = pending_reg;
        ticks_next    = ticks_reg;
        kind_next     = kind_reg;
        accepted_next = accepted_reg;
        chon_next     = chon_reg;
        byte_next     = byte_reg;
        latch_next    = latch_reg;

        if (cmd.exec_tick)
        begin
            pending_next = 1'b0;
            ticks_next   = tick_pend ? 16'd0 : ticks_inc;
        end

        if (cmd.exec_all_off)
        begin
            for (int i = 0; i < MAX_MODULES; i++)
            begin
                if (i < int'(used_n))
                begin
                    on_next[i] = '0;
                end
            end
        end

        if (cmd.exec_cmd)
        begin
            kind_next     = 1'b0;
            accepted_next = 1'b1;
            chon_next     = 1'b0;
            byte_next     = '0;
            latch_next    = 1'b0;
            if (ch_reg == CH_INVALID)
            begin
                accepted_next = 1'b0;
            end
            else if (hit)
            begin
                unique case (op_reg)
                    OP_OPEN, OP_CLOSE:
                    begin
                        if (locked)
                        begin
                            // refused, but the request is remembered
                            saved_next[cm] = (op_reg == OP_OPEN) ? (saved_sel | mask)
                                                                 : (saved_sel & ~mask);
                            accepted_next  = 1'b0;
                        end
                        else
                        begin
                            on_next[cm]  = (op_reg == OP_OPEN) ? (on_sel | mask)
                                                               : (on_sel & ~mask);
                            pending_next = 1'b1;
                        end
                    end
                    OP_LOCK:
                    begin
                        if (!locked)
                        begin
                            lock_next[cm]  = lock_sel | mask;
                            saved_next[cm] = (saved_sel & ~mask) | (on_sel & mask);
                            on_next[cm]    = level_reg ? (on_sel | mask) : (on_sel & ~mask);
                            pending_next   = 1'b1;
                        end
                    end
                    OP_UNLOCK:
                    begin
                        if (locked)
                        begin
                            lock_next[cm] = lock_sel & ~mask;
                            on_next[cm]   = (on_sel & ~mask) | (saved_sel & mask);
                            pending_next  = 1'b1;
                        end
                    end
                    default:
                    begin
                        chon_next = (on_sel & mask) != '0;
                    end
                endcase
            end
        end

        if (cmd.load_byte)
        begin
            kind_next     = 1'b1;
            accepted_next = 1'b0;
            chon_next     = 1'b0;
            byte_next     = raw_byte;
            latch_next    = (cmd.emit_idx == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_count_reg <= '0;
            active_low_reg   <= 8'hFF;
            inverted_reg     <= '0;
            refresh_reg      <= REFRESH_RESET;
            for (int i = 0; i < MAX_MODULES; i++)
            begin
                on_reg[i]    <= '0;
                lock_reg[i]  <= '0;
                saved_reg[i] <= '0;
            end
            pending_reg <= 1'b0;
            ticks_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MODULE_COUNT:  module_count_reg <= cfg_data[3:0];
                    CFG_ACTIVE_LOW:    active_low_reg   <= cfg_data[7:0];
                    CFG_INVERTED:      inverted_reg     <= cfg_data[7:0];
                    CFG_REFRESH_TICKS: refresh_reg      <= cfg_data;
                    default:           ;
                endcase
            end
            for (int i = 0; i < MAX_MODULES; i++)
            begin
                on_reg[i]    <= on_next[i];
                lock_reg[i]  <= lock_next[i];
                saved_reg[i] <= saved_next[i];
            end
            pending_reg <= pending_next;
            ticks_reg   <= ticks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            ch_reg    <= channel;
            level_reg <= lock_level;
        end
        kind_reg     <= kind_next;
        accepted_reg <= accepted_next;
        chon_reg     <= chon_next;
        byte_reg     <= byte_next;
        latch_reg    <= latch_next;
    end

    assign kind       = kind_reg;
    assign accepted   = accepted_reg;
    assign channel_on = chon_reg;
    assign shift_byte = byte_reg;
    assign latch_now  = latch_reg;

endmodule

FILE: hw/rtl/relay_channel_lock_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_channel_lock_controller
// Channel on/lock bookkeeping for a chain of shift-register relay modules.
// ----------------------------------------------------------------------------
// One command is handled at a time. A channel command is captured at its
// transfer and, once the output register is free, executed into it; the input
// is free again after that (later while a previous result is still stalled).
// A tick with nothing to write or an ignored op frees the input after the
// execute state without a reply. A rewrite or all-off then produces one module
// byte per cycle from the output register while the output is not stalled,
// last module first, and holds the input off until the last byte is loaded.
// The sequencer's single output register sets this pace.
// ----------------------------------------------------------------------------
module relay_channel_lock_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rclc_pkg::OP_W-1:0]       op,
    input  logic [rclc_pkg::CH_W-1:0]       channel,
    input  logic                            lock_level,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            kind,
    output logic                            accepted,
    output logic                            channel_on,
    output logic [7:0]                      shift_byte,
    output logic                            latch_now,
    input  logic                            cfg_we,
    input  logic [rclc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rclc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rclc_pkg::*;

    rclc_cmd_t    cmd;
    rclc_status_t st;

    rclc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    rclc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .channel    (channel),
        .lock_level (lock_level),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .st         (st),
        .kind       (kind),
        .accepted   (accepted),
        .channel_on (channel_on),
        .shift_byte (shift_byte),
        .latch_now  (latch_now)
    );

endmodule

FILE: sim/relay_channel_lock_controller_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_channel_lock_controller_checker
// Watches the command, result and register ports of the relay lock controller,
// keeps its own copy of the channel, lock and refresh state, and compares every
// reply and module byte against the word it predicts from accepted commands.
// ----------------------------------------------------------------------------
module relay_channel_lock_controller_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [rclc_pkg::OP_W-1:0]       op,
    input  logic [rclc_pkg::CH_W-1:0]       channel,
    input  logic                            lock_level,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic                            kind,
    input  logic                            accepted,
    input  logic                            channel_on,
    input  logic [7:0]                      shift_byte,
    input  logic                            latch_now,
    input  logic                            cfg_we,
    input  logic [rclc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rclc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              backlog
);

    import rclc_pkg::*;

    typedef struct packed {
        logic       kind;
        logic       accepted;
        logic       channel_on;
        logic [7:0] shift_byte;
        logic       latch_now;
    } relay_word_t;

    relay_word_t relay_words[$];

    logic [3:0]  cfg_modules;
    logic [7:0]  cfg_active_low;
    logic [7:0]  cfg_inverted;
    logic [15:0] cfg_refresh;

    logic [7:0]  on_bits    [MAX_MODULES];
    logic [7:0]  lock_bits  [MAX_MODULES];
    logic [7:0]  saved_bits [MAX_MODULES];
    logic        update_due;
    logic [15:0] tick_count;

    int mismatches = 0;

    assign fail_count = mismatches;

    function automatic int used_modules();
        return (cfg_modules > MAX_MODULES) ? MAX_MODULES : int'(cfg_modules);
    endfunction

    task automatic push_reply(input logic acc, input logic on);
        relay_word_t w;
        w = '0;
        w.accepted = acc;
        w.channel_on = on;
        relay_words.push_back(w);
    endtask

    // last module leaves first; latch marks the final byte
    task automatic push_module_bytes();
        relay_word_t w;
        int n;
        int m;
        n = used_modules();
        for (int k = 0; k < n; k++)
        begin
            m = n - 1 - k;
            w = '0;
            w.kind = 1'b1;
            w.shift_byte = cfg_active_low[m] ? ~on_bits[m] : on_bits[m];
            w.latch_now = (k + 1 == n);
            relay_words.push_back(w);
        end
    endtask

    task automatic run_relay_cmd(input logic [OP_W-1:0] cmd, input logic [CH_W-1:0] ch,
                                 input logic lvl);
        int n;
        int c;
        int m;
        int b;
        n = used_modules();
        case (cmd)
            OP_TICK:
            begin
                if (tick_count != 16'hFFFF)
                    tick_count = tick_count + 16'd1;
                if (tick_count >= cfg_refresh)
                    update_due = 1'b1;
                if (update_due)
                begin
                    update_due = 1'b0;
                    tick_count = '0;
                    push_module_bytes();
                end
            end
            OP_ALL_OFF:
            begin
                // locks and saved requests survive an all-off
                for (int i = 0; i < n; i++)
                    on_bits[i] = 8'h00;
                push_module_bytes();
            end
            OP_NONE:
            begin
            end
            default:
            begin
                c = int'(ch) - 1;
                if (ch == CH_INVALID)
                    push_reply(1'b0, 1'b0);
                else if (ch == '0 || (c >> 3) >= n)
                    push_reply(1'b1, 1'b0);
                else
                begin
                    m = c >> 3;
                    b = c & 7;
                    if (cfg_inverted[m])
                        b = 7 - b;
                    case (cmd)
                        OP_OPEN, OP_CLOSE:
                        begin
                            if (lock_bits[m][b])
                            begin
                                saved_bits[m][b] = (cmd == OP_OPEN);
                                push_reply(1'b0, 1'b0);
                            end
                            else
                            begin
                                on_bits[m][b] = (cmd == OP_OPEN);
                                update_due = 1'b1;
                                push_reply(1'b1, 1'b0);
                            end
                        end
                        OP_LOCK:
                        begin
                            if (!lock_bits[m][b])
                            begin
                                lock_bits[m][b] = 1'b1;
                                saved_bits[m][b] = on_bits[m][b];
                                on_bits[m][b] = lvl;
                                update_due = 1'b1;
                            end
                            push_reply(1'b1, 1'b0);
                        end
                        OP_UNLOCK:
                        begin
                            if (lock_bits[m][b])
                            begin
                                lock_bits[m][b] = 1'b0;
                                on_bits[m][b] = saved_bits[m][b];
                                update_due = 1'b1;
                            end
                            push_reply(1'b1, 1'b0);
                        end
                        default:
                            push_reply(1'b1, on_bits[m][b]);
                    endcase
                end
            end
        endcase
    endtask

    task automatic check_word();
        relay_word_t got;
        relay_word_t want;
        got.kind = kind;
        got.accepted = accepted;
        got.channel_on = channel_on;
        got.shift_byte = shift_byte;
        got.latch_now = latch_now;
        if (relay_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result kind=%0d acc=%0d on=%0d byte=%02h latch=%0d",
                         $time, got.kind, got.accepted, got.channel_on, got.shift_byte,
                         got.latch_now);
        end
        else
        begin
            want = relay_words.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch want kind=%0d acc=%0d on=%0d byte=%02h latch=%0d",
                             $time, want.kind, want.accepted, want.channel_on,
                             want.shift_byte, want.latch_now);
                    $display("%0t:          got  kind=%0d acc=%0d on=%0d byte=%02h latch=%0d",
                             $time, got.kind, got.accepted, got.channel_on,
                             got.shift_byte, got.latch_now);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_modules = 4'd0;
            cfg_active_low = 8'hFF;
            cfg_inverted = 8'h00;
            cfg_refresh = REFRESH_RESET;
            for (int i = 0; i < MAX_MODULES; i++)
            begin
                on_bits[i] = 8'h00;
                lock_bits[i] = 8'h00;
                saved_bits[i] = 8'h00;
            end
            update_due = 1'b0;
            tick_count = '0;
            relay_words.delete();
            backlog <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_word();
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODULE_COUNT:  cfg_modules = cfg_data[3:0];
                    CFG_ACTIVE_LOW:    cfg_active_low = cfg_data[7:0];
                    CFG_INVERTED:      cfg_inverted = cfg_data[7:0];
                    CFG_REFRESH_TICKS: cfg_refresh = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                run_relay_cmd(op, channel, lock_level);
            backlog <= relay_words.size();
        end
    end

endmodule

FILE: sim/relay_channel_lock_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_channel_lock_controller_tb
// Drives directed and random relay commands through several register setups
// with random gaps and output stalls; the checker predicts and compares, this
// top gives the verdict.
// ----------------------------------------------------------------------------
module relay_channel_lock_controller_tb;

    import rclc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN       = 16;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       op = OP_NONE;
    logic [CH_W-1:0]       channel = '0;
    logic                  lock_level = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  kind;
    logic                  accepted;
    logic                  channel_on;
    logic [7:0]            shift_byte;
    logic                  latch_now;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int fail_count;
    int backlog;
    int cycles = 0;
    int quiet_left = 0;
    int span_mods = 0;
    logic [CH_W-1:0] hot_ch [4];

    relay_channel_lock_controller dut (.*);

    relay_channel_lock_controller_checker checker_i (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: mostly short open stretches, some short stalls, some long stalls, a few long open stretches
    initial
    begin
        int r;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else if (r < 85)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else if (r < 95)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(8, 40)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(60, 200)) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            quiet_left = $urandom_range(8, 25);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send(input logic [OP_W-1:0] cmd, input logic [CH_W-1:0] ch,
                        input logic lvl);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= cmd;
        channel <= ch;
        lock_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // upper data bits of the narrow registers are junk on purpose; the block must drop them
    task automatic configure(input logic [3:0] mods, input logic [7:0] act_low,
                             input logic [7:0] inv, input logic [15:0] refresh);
        logic [15:0] junk;
        settle();
        junk = $urandom;
        cfg_we <= 1'b1;
        cfg_index <= CFG_MODULE_COUNT;
        cfg_data <= {junk[15:4], mods};
        @(posedge clk);
        cfg_index <= CFG_ACTIVE_LOW;
        cfg_data <= {junk[7:0], act_low};
        @(posedge clk);
        cfg_index <= CFG_INVERTED;
        cfg_data <= {junk[15:8], inv};
        @(posedge clk);
        cfg_index <= CFG_REFRESH_TICKS;
        cfg_data <= refresh;
        @(posedge clk);
        cfg_we <= 1'b0;
        span_mods = (mods > MAX_MODULES) ? MAX_MODULES : int'(mods);
        for (int i = 0; i < 4; i++)
            hot_ch[i] = (span_mods > 0) ? CH_W'($urandom_range(1, 8 * span_mods)) : '0;
    endtask

    task automatic random_cmds(input int count);
        int r;
        logic [OP_W-1:0] cmd;
        logic [CH_W-1:0] ch;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 22)      cmd = OP_OPEN;
            else if (r < 40) cmd = OP_CLOSE;
            else if (r < 54) cmd = OP_LOCK;
            else if (r < 66) cmd = OP_UNLOCK;
            else if (r < 78) cmd = OP_QUERY;
            else if (r < 92) cmd = OP_TICK;
            else if (r < 97) cmd = OP_ALL_OFF;
            else             cmd = OP_NONE;
            r = $urandom_range(0, 99);
            if (span_mods == 0 || r < 10)
                ch = CH_W'($urandom_range(0, 255));
            else if (r < 15)
                ch = CH_INVALID;
            else if (r < 55)
                ch = hot_ch[$urandom_range(0, 3)];
            else
                ch = CH_W'($urandom_range(0, 8 * span_mods + 2));
            send(cmd, ch, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // two modules: module 0 active low, module 1 bit-reversed
        configure(4'd2, 8'h01, 8'h02, 16'd3);
        send(OP_QUERY, 8'd0, 1'b0);
        send(OP_QUERY, CH_INVALID, 1'b0);
        send(OP_OPEN, CH_INVALID, 1'b0);
        send(OP_OPEN, 8'd1, 1'b0);
        send(OP_OPEN, 8'd9, 1'b1);
        send(OP_OPEN, 8'd16, 1'b0);
        send(OP_QUERY, 8'd1, 1'b0);
        send(OP_QUERY, 8'd17, 1'b0);
        send(OP_TICK, 8'd0, 1'b0);
        send(OP_LOCK, 8'd1, 1'b0);
        send(OP_LOCK, 8'd1, 1'b1);       // already locked
        send(OP_OPEN, 8'd1, 1'b0);       // refused, request saved
        send(OP_CLOSE, 8'd1, 1'b0);
        send(OP_OPEN, 8'd1, 1'b0);
        send(OP_UNLOCK, 8'd1, 1'b0);     // restores saved on
        send(OP_UNLOCK, 8'd1, 1'b0);     // not locked
        send(OP_LOCK, 8'd10, 1'b1);
        send(OP_CLOSE, 8'd2, 1'b0);      // no level change, still an update
        send(OP_ALL_OFF, 8'd0, 1'b0);
        send(OP_TICK, 8'd0, 1'b0);
        send(OP_TICK, 8'd0, 1'b0);
        send(OP_TICK, 8'd0, 1'b0);
        send(OP_TICK, 8'd0, 1'b0);       // refresh period reached
        send(OP_NONE, 8'hAA, 1'b1);
        send(OP_QUERY, 8'd254, 1'b1);
        send(OP_UNLOCK, CH_INVALID, 1'b1);

        configure(4'd8, 8'hFF, 8'h00, 16'hFFFF);
        random_cmds(60);
        configure(4'd15, 8'h00, 8'hFF, 16'd1);
        random_cmds(60);
        configure(4'd0, 8'($urandom), 8'($urandom), 16'd0);
        random_cmds(20);
        configure(4'd1, 8'($urandom), 8'($urandom), 16'($urandom_range(2, 20)));
        random_cmds(50);
        configure(4'($urandom_range(4, 7)), 8'($urandom), 8'($urandom),
                  16'($urandom_range(1, 10)));
        random_cmds(70);
        configure(4'd8, 8'hA5, 8'h5A, 16'd5);
        random_cmds(60);

        settle();
        if (fail_count == 0 && backlog == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: relay_channel_lock_controller.f
hw/rtl/rclc_pkg.sv
hw/rtl/rclc_ctrl.sv
hw/rtl/rclc_datapath.sv
hw/rtl/relay_channel_lock_controller.sv
sim/relay_channel_lock_controller_checker.sv
sim/relay_channel_lock_controller_tb.sv
